// ----- hw/rtl/mp4bw_pkg.sv -----
// Package for the MP4 box walker: box names, phase, step and status codes.
// No dependencies.
`default_nettype none
package mp4bw_pkg;

  localparam logic [31:0] NAME_FTYP = 32'h6674_7970;
  localparam logic [31:0] NAME_MOOV = 32'h6D6F_6F76;
  localparam logic [31:0] NAME_MVHD = 32'h6D76_6864;
  localparam logic [3:0]  NAME_BYTES = 4'd4;

  // search step
  localparam logic [1:0] STEP_FTYP = 2'd0;
  localparam logic [1:0] STEP_MOOV = 2'd1;
  localparam logic [1:0] STEP_MVHD = 2'd2;
  localparam logic [1:0] STEP_DONE = 2'd3;

  // field phase
  localparam logic [2:0] PH_SIZE    = 3'd0;
  localparam logic [2:0] PH_EXTSIZE = 3'd1;
  localparam logic [2:0] PH_NAME    = 3'd2;
  localparam logic [2:0] PH_SKIP    = 3'd3;
  localparam logic [2:0] PH_VERSION = 3'd4;
  localparam logic [2:0] PH_FLAGS   = 3'd5;
  localparam logic [2:0] PH_TIME    = 3'd6;

  // result status
  localparam logic [1:0] ST_TIME  = 2'd0;
  localparam logic [1:0] ST_SMALL = 2'd1;
  localparam logic [1:0] ST_EARLY = 2'd2;

  localparam int unsigned TDATA_W = 72;

endpackage
`default_nettype wire

// ----- hw/rtl/mp4_box_walk_creation_time.sv -----
// MP4 box walker: extracts the mvhd creation time from a byte stream.
// Depends on mp4bw_pkg.
// A result is in the output register in the cycle after the byte that completes it.
// Throughput: one byte per cycle; bytes are taken while a result waits if it drains that cycle.
// The rate is set by the combinational header update (64-bit shift, compare, subtract).
// Reset (rst, synchronous): walker back to seeking ftyp, output register empty.
`default_nettype none
module mp4_box_walk_creation_time (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [mp4bw_pkg::TDATA_W-1:0] m_axis_tdata, // header_version[7:0], creation_time[71:8]
  output logic [1:0]       m_axis_tuser    // status
);

  logic [1:0]  search_step, search_step_next;
  logic [2:0]  field_phase, field_phase_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [63:0] box_size, box_size_next;
  logic [31:0] box_name, box_name_next;
  logic [63:0] skip_remaining, skip_remaining_next;
  logic [7:0]  version_seen, version_seen_next;
  logic [63:0] time_accumulator, time_accumulator_next;

  logic        res_valid;
  logic [1:0]  res_status;
  logic [7:0]  res_version;
  logic [63:0] res_time;

  logic        take;
  logic [3:0]  bc_inc;
  logic [63:0] size_in;
  logic [63:0] size_shift;
  logic [63:0] size_sub;
  logic [31:0] name_shift;
  logic [63:0] skip_dec;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign take = s_axis_tvalid && s_axis_tready;

  always_comb begin
    size_in = box_size;
    if (field_phase != mp4bw_pkg::PH_EXTSIZE && (field_phase != mp4bw_pkg::PH_SIZE ||
        byte_count == 4'd0)) begin
      size_in = '0;
    end
    size_shift = {size_in[55:0], s_axis_tdata};
    size_sub   = size_shift - ((field_phase == mp4bw_pkg::PH_EXTSIZE) ? 64'd16 : 64'd8);
    name_shift = {box_name[23:0], s_axis_tdata};
    skip_dec   = (skip_remaining != 64'd0) ? skip_remaining - 64'd1 : skip_remaining;
    bc_inc     = byte_count + 4'd1;
  end

  always_comb begin
    search_step_next      = search_step;
    field_phase_next      = field_phase;
    byte_count_next       = byte_count;
    box_size_next         = box_size;
    box_name_next         = box_name;
    skip_remaining_next   = skip_remaining;
    version_seen_next     = version_seen;
    time_accumulator_next = time_accumulator;
    res_valid   = 1'b0;
    res_status  = mp4bw_pkg::ST_TIME;
    res_version = '0;
    res_time    = '0;

    if (search_step != mp4bw_pkg::STEP_DONE) begin
      case (field_phase)
        mp4bw_pkg::PH_EXTSIZE: begin
          box_size_next   = size_shift;
          byte_count_next = bc_inc;
          if (bc_inc >= 4'd8) begin
            byte_count_next = '0;
            if (size_shift < 64'd16) begin
              res_valid  = 1'b1;
              res_status = mp4bw_pkg::ST_SMALL;
            end else begin
              skip_remaining_next = size_sub;
              box_name_next       = '0;
              field_phase_next    = mp4bw_pkg::PH_NAME;
            end
          end
        end
        mp4bw_pkg::PH_NAME: begin
          box_name_next   = name_shift;
          byte_count_next = bc_inc;
          if (bc_inc >= mp4bw_pkg::NAME_BYTES) begin
            byte_count_next  = '0;
            field_phase_next = (skip_remaining == 64'd0) ? mp4bw_pkg::PH_SIZE
                                                         : mp4bw_pkg::PH_SKIP;
            if (search_step == mp4bw_pkg::STEP_FTYP) begin
              if (name_shift == mp4bw_pkg::NAME_FTYP) begin
                search_step_next = mp4bw_pkg::STEP_MOOV;
              end
            end else if (search_step == mp4bw_pkg::STEP_MOOV) begin
              if (name_shift == mp4bw_pkg::NAME_MOOV) begin
                search_step_next    = mp4bw_pkg::STEP_MVHD;
                skip_remaining_next = '0;
                field_phase_next    = mp4bw_pkg::PH_SIZE;
              end
            end else if (name_shift == mp4bw_pkg::NAME_MVHD) begin
              field_phase_next = mp4bw_pkg::PH_VERSION;
            end
          end
        end
        mp4bw_pkg::PH_SKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 64'd0) begin
            field_phase_next = mp4bw_pkg::PH_SIZE;
          end
        end
        mp4bw_pkg::PH_VERSION: begin
          version_seen_next = s_axis_tdata;
          byte_count_next   = '0;
          field_phase_next  = mp4bw_pkg::PH_FLAGS;
        end
        mp4bw_pkg::PH_FLAGS: begin
          byte_count_next = bc_inc;
          if (bc_inc >= 4'd3) begin
            byte_count_next       = '0;
            time_accumulator_next = '0;
            field_phase_next      = mp4bw_pkg::PH_TIME;
          end
        end
        mp4bw_pkg::PH_TIME: begin
          time_accumulator_next = {time_accumulator[55:0], s_axis_tdata};
          byte_count_next       = bc_inc;
          if (bc_inc >= ((version_seen == 8'd1) ? 4'd8 : 4'd4)) begin
            byte_count_next = '0;
            res_valid   = 1'b1;
            res_status  = mp4bw_pkg::ST_TIME;
            res_version = version_seen;
            res_time    = time_accumulator_next;
          end
        end
        default: begin
          // size field; an unknown phase code restarts the header
          field_phase_next = mp4bw_pkg::PH_SIZE;
          box_size_next    = size_shift;
          byte_count_next  = (field_phase != mp4bw_pkg::PH_SIZE) ? 4'd1 : bc_inc;
          if (byte_count_next >= 4'd4) begin
            byte_count_next = '0;
            if (size_shift == 64'd1) begin
              box_size_next    = '0;
              field_phase_next = mp4bw_pkg::PH_EXTSIZE;
            end else if (size_shift < 64'd8) begin
              res_valid  = 1'b1;
              res_status = mp4bw_pkg::ST_SMALL;
            end else begin
              skip_remaining_next = size_sub;
              box_name_next       = '0;
              field_phase_next    = mp4bw_pkg::PH_NAME;
            end
          end
        end
      endcase
      if (!res_valid && s_axis_tlast) begin
        res_valid  = 1'b1;
        res_status = mp4bw_pkg::ST_EARLY;
      end
      if (res_valid) begin
        search_step_next = mp4bw_pkg::STEP_DONE;
      end
    end

    if (s_axis_tlast) begin
      search_step_next      = mp4bw_pkg::STEP_FTYP;
      field_phase_next      = mp4bw_pkg::PH_SIZE;
      byte_count_next       = '0;
      box_size_next         = '0;
      box_name_next         = '0;
      skip_remaining_next   = '0;
      version_seen_next     = '0;
      time_accumulator_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_step      <= mp4bw_pkg::STEP_FTYP;
      field_phase      <= mp4bw_pkg::PH_SIZE;
      byte_count       <= '0;
      box_size         <= '0;
      box_name         <= '0;
      skip_remaining   <= '0;
      version_seen     <= '0;
      time_accumulator <= '0;
    end else if (take) begin
      search_step      <= search_step_next;
      field_phase      <= field_phase_next;
      byte_count       <= byte_count_next;
      box_size         <= box_size_next;
      box_name         <= box_name_next;
      skip_remaining   <= skip_remaining_next;
      version_seen     <= version_seen_next;
      time_accumulator <= time_accumulator_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take && res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      m_axis_tdata <= {res_time, res_version};
      m_axis_tuser <= res_status;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mp4bw_checker.sv -----
// Port-level checks for the MP4 box walker, bound to the top level.
// Depends on mp4bw_pkg and mp4_box_walk_creation_time.
`default_nettype none
module mp4bw_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [mp4bw_pkg::TDATA_W-1:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == mp4bw_pkg::ST_TIME ||
                       m_axis_tuser == mp4bw_pkg::ST_SMALL ||
                       m_axis_tuser == mp4bw_pkg::ST_EARLY))
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != mp4bw_pkg::ST_TIME |-> m_axis_tdata == '0)
    else $error("error item carries data");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind mp4_box_walk_creation_time mp4bw_checker u_mp4bw_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
`default_nettype wire
